[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the periodic waveform generator.
// Each macro checks a property on the rising edge of clk, disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define PWG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pwg assertion failed");

// Next-cycle implication.
`define PWG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pwg assertion failed");

`else

`define PWG_ASSERT_IMP(label, ante, cons)
`define PWG_ASSERT_NXT(label, ante, cons)

`endif

`endif

[hw/rtl/pwg_pkg.sv]
// Package of the periodic waveform generator: wave codes, register indexes,
// fixed-point constants, controller states and the quarter-wave table function.
package pwg_pkg;

  localparam int LEVEL_W    = 16;
  localparam int PHASE_W    = 12;
  localparam int AMP_W      = 14;
  localparam int CFG_W      = 14;
  localparam int REM_W      = 30;
  localparam int DVD_W      = 16;
  localparam int CNT_W      = 5;

  localparam int SINE_DEPTH = 256;
  localparam int DEPTH_BITS = $clog2(SINE_DEPTH);
  localparam int T_BITS     = DEPTH_BITS + 2;
  localparam int IDX_W      = DEPTH_BITS + 1;

  localparam logic [2:0] WAVE_OFF      = 3'd0;
  localparam logic [2:0] WAVE_SINE     = 3'd1;
  localparam logic [2:0] WAVE_SQUARE   = 3'd2;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
  localparam logic [2:0] WAVE_SAW_RISE = 3'd4;
  localparam logic [2:0] WAVE_SAW_FALL = 3'd5;

  localparam logic [1:0] REG_WAVE_TYPE = 2'd0;
  localparam logic [1:0] REG_PERIOD    = 2'd1;
  localparam logic [1:0] REG_AMPLITUDE = 2'd2;
  localparam logic [1:0] REG_DIRECTION = 2'd3;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 16'hFFFF;
  localparam logic [AMP_W-1:0]   AMP_FULL   = 14'd10000;
  localparam logic [REM_W-1:0]   DRIVE_DEN  = 30'd655350000;
  localparam logic [PHASE_W-1:0] PERIOD_RST = 12'd200;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210, 64'd272};

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_PREP   = 11'b000_0000_0010,
    S_LOAD   = 11'b000_0000_0100,
    S_WDIV   = 11'b000_0000_1000,
    S_WEND   = 11'b000_0001_0000,
    S_SCALE  = 11'b000_0010_0000,
    S_MUL    = 11'b000_0100_0000,
    S_DLOAD  = 11'b000_1000_0000,
    S_DDIV   = 11'b001_0000_0000,
    S_DEND   = 11'b010_0000_0000,
    S_FINISH = 11'b100_0000_0000
  } pwg_state_t;

  // Quarter-wave sine entry k in Q0.16, from a Q30 Taylor series.
  function automatic logic [LEVEL_W-1:0] qtab_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        s;
    logic [63:0]        v;
    logic signed [63:0] sum;
    x    = (HALF_PI_Q30 * 64'(k)) / SINE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int i = 0; i < 8; i++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[i];
      if (i[0] == 1'b0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    s = sum[63] ? 64'd0 : $unsigned(sum);
    v = (s * 64'd65535 + (Q30_ONE >> 1)) >> 30;
    if (v > 64'(LEVEL_ONE)) begin
      v = 64'(LEVEL_ONE);
    end
    return v[LEVEL_W-1:0];
  endfunction

  localparam logic [LEVEL_W-1:0] Q_TOP = qtab_entry(SINE_DEPTH);

endpackage

[hw/rtl/pwg_if.sv]
// Stream interfaces of the periodic waveform generator: the tick channel and
// the sample channel, each with valid, ready and its item. Uses pwg_pkg.
interface pwg_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface pwg_sample_if import pwg_pkg::*; #(
  parameter int DAC_W = 11
);
  logic                       valid;
  logic                       ready;
  logic signed [DAC_W-1:0]    dac_level;
  logic        [LEVEL_W-1:0]  wave_level;
  logic        [PHASE_W-1:0]  phase_index;
  logic                       active;

  modport source (output valid, output dac_level, output wave_level,
                  output phase_index, output active, input ready);
  modport sink (input valid, input dac_level, input wave_level,
                input phase_index, input active, output ready);
endinterface

[hw/rtl/periodic_waveform_generator.sv]
// Top level of the periodic waveform generator: phase counter, bit-serial
// divider and multiplier, quarter-wave table. Uses pwg_pkg, pwg_if, assert_macros.svh.
//
// Each tick item produces one sample item. The block works on one item at a time;
// an item skips all arithmetic when the wave is off, skips the wave division for
// square, and uses both divisions of the shared restoring divider for sine,
// triangle and saw. The divider retires one quotient bit per cycle; the amplitude
// is applied by a 14-step shift-add multiplier. A finished sample waits in an output
// register, so the next tick is taken while it is still unread; the sample after
// that holds the block until the waiting one is read. The sample interface must be
// instantiated with DAC_W = clog2(DAC_MAX + 1) + 1.
`include "assert_macros.svh"

module periodic_waveform_generator import pwg_pkg::*; #(
  parameter int DAC_MAX = 1023
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  pwg_tick_if.sink           tick,
  pwg_sample_if.source       sample
);

  localparam int QW   = $clog2(DAC_MAX + 1);
  localparam int DACW = QW + 1;
  localparam int MW   = LEVEL_W + QW;
  localparam int AW   = MW + AMP_W;

  pwg_state_t state;

  logic [2:0]          wave_type;
  logic [PHASE_W-1:0]  samples_per_period;
  logic [AMP_W-1:0]    amplitude_hundredths;
  logic                direction_forward;
  logic [PHASE_W-1:0]  phase_count;

  logic [2:0]          wtype;
  logic [PHASE_W-1:0]  p_reg;
  logic [PHASE_W-1:0]  n_reg;
  logic                act_reg;
  logic [PHASE_W-1:0]  num;
  logic [LEVEL_W-1:0]  level;
  logic signed [DACW-1:0] dac;
  logic [REM_W-1:0]    rem;
  logic [DVD_W-1:0]    dvd;
  logic [REM_W-1:0]    dsr;
  logic [CNT_W-1:0]    cnt;
  logic [MW-1:0]       mcand;
  logic [AMP_W-1:0]    amp_sh;
  logic [AW-1:0]       acc;

  logic                out_valid;
  logic signed [DACW-1:0] out_dac;
  logic [LEVEL_W-1:0]  out_level;
  logic [PHASE_W-1:0]  out_phase;
  logic                out_active;

  logic [LEVEL_W-1:0]  quarter_tab [SINE_DEPTH];

  for (genvar k = 0; k < SINE_DEPTH; k++) begin : g_tab
    assign quarter_tab[k] = qtab_entry(k);
  end

  // Tick acceptance and phase counter.
  logic                accept;
  logic [PHASE_W-1:0]  p_eff;
  logic [PHASE_W-1:0]  n_now;
  logic [PHASE_W:0]    n_inc;
  logic                act_now;

  assign tick.ready = (state == S_IDLE);
  assign accept     = tick.valid && tick.ready;
  assign p_eff      = (samples_per_period == '0) ? PHASE_W'(1) : samples_per_period;
  assign n_now      = (tick.restart || phase_count >= p_eff) ? '0 : phase_count;
  assign n_inc      = {1'b0, n_now} + (PHASE_W+1)'(1);
  assign act_now    = (wave_type >= WAVE_SINE) && (wave_type <= WAVE_SAW_FALL);

  // Divider step and rounding compare, shared by both divisions.
  logic [REM_W:0]      rem2;
  logic                ge;
  logic [REM_W:0]      rem_sub;
  logic [REM_W-1:0]    rem_step;
  logic                round_up;

  assign rem2     = {rem, dvd[DVD_W-1]};
  assign ge       = rem2 >= {1'b0, dsr};
  assign rem_sub  = rem2 - {1'b0, dsr};
  assign rem_step = ge ? rem_sub[REM_W-1:0] : rem2[REM_W-1:0];
  assign round_up = {rem, 1'b0} >= {1'b0, dsr};

  // Numerator of the ramp waves.
  logic [PHASE_W:0]    two_n;
  logic [PHASE_W:0]    span;
  logic [PHASE_W-1:0]  num_next;

  assign two_n = {n_reg, 1'b0};
  assign span  = ({1'b0, p_reg} > two_n) ? {1'b0, p_reg} - two_n : two_n - {1'b0, p_reg};

  always_comb begin
    unique case (wtype)
      WAVE_TRIANGLE: num_next = p_reg - span[PHASE_W-1:0];
      WAVE_SAW_RISE: num_next = n_reg;
      default:       num_next = p_reg - n_reg;
    endcase
  end

  // Sine level from the quadrant and table offset.
  logic [T_BITS-1:0]     t_val;
  logic [1:0]            quad;
  logic [DEPTH_BITS-1:0] r_val;
  logic                  mirror;
  logic                  c_pos;
  logic [IDX_W-1:0]      idx;
  logic [LEVEL_W-1:0]    tab_val;
  logic [LEVEL_W:0]      sine_sum;

  assign t_val    = dvd[T_BITS-1:0];
  assign quad     = t_val[T_BITS-1 -: 2];
  assign r_val    = t_val[DEPTH_BITS-1:0];
  assign mirror   = (quad == 2'd0) || (quad == 2'd2);
  assign c_pos    = (quad == 2'd0) || (quad == 2'd3);
  assign idx      = mirror ? IDX_W'(SINE_DEPTH) - {1'b0, r_val} : {1'b0, r_val};
  assign tab_val  = idx[DEPTH_BITS] ? Q_TOP : quarter_tab[idx[DEPTH_BITS-1:0]];
  assign sine_sum = c_pos ? (LEVEL_W+1)'(17'h10000) - {1'b0, tab_val}
                          : (LEVEL_W+1)'(17'h10000) + {1'b0, tab_val};

  // Drive magnitude.
  logic [QW-1:0] mag;

  assign mag = dvd[QW-1:0] + QW'(round_up);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_type            <= WAVE_OFF;
      samples_per_period   <= PERIOD_RST;
      amplitude_hundredths <= AMP_FULL;
      direction_forward    <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WAVE_TYPE: wave_type            <= cfg_data[2:0];
        REG_PERIOD:    samples_per_period   <= cfg_data[PHASE_W-1:0];
        REG_AMPLITUDE: amplitude_hundredths <= cfg_data[AMP_W-1:0];
        REG_DIRECTION: direction_forward    <= cfg_data[0];
      endcase
    end
  end

  // Controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if ((state == S_FINISH) && (!out_valid || sample.ready)) begin
        out_valid <= 1'b1;
      end else if (sample.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state   <= S_PREP;
            wtype   <= wave_type;
            p_reg   <= p_eff;
            n_reg   <= n_now;
            act_reg <= act_now;
            if (act_now) begin
              phase_count <= (n_inc >= {1'b0, p_eff}) ? '0 : n_inc[PHASE_W-1:0];
            end else begin
              phase_count <= n_now;
            end
          end
        end
        S_PREP: begin
          num <= num_next;
          if (!act_reg) begin
            level <= '0;
            dac   <= '0;
            state <= S_FINISH;
          end else if (wtype == WAVE_SQUARE) begin
            level <= (n_reg >= (p_reg >> 1)) ? '0 : LEVEL_ONE;
            state <= S_SCALE;
          end else begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          dsr <= REM_W'(p_reg);
          if (wtype == WAVE_SINE) begin
            rem <= REM_W'(n_reg);
            dvd <= '0;
            cnt <= CNT_W'(T_BITS);
          end else begin
            rem <= (num == '0) ? '0 : REM_W'(num - PHASE_W'(1));
            dvd <= DVD_W'(-{4'b0, num});
            cnt <= CNT_W'(DVD_W);
          end
          state <= S_WDIV;
        end
        S_WDIV: begin
          rem <= rem_step;
          dvd <= {dvd[DVD_W-2:0], ge};
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= S_WEND;
          end
        end
        S_WEND: begin
          if (wtype == WAVE_SINE) begin
            level <= sine_sum[LEVEL_W:1];
          end else begin
            level <= dvd + LEVEL_W'(round_up);
          end
          state <= S_SCALE;
        end
        S_SCALE: begin
          mcand  <= MW'(level * DAC_MAX);
          amp_sh <= (amplitude_hundredths > AMP_FULL) ? AMP_FULL : amplitude_hundredths;
          acc    <= '0;
          cnt    <= CNT_W'(AMP_W);
          state  <= S_MUL;
        end
        S_MUL: begin
          acc    <= (acc << 1) + (amp_sh[AMP_W-1] ? AW'(mcand) : AW'(0));
          amp_sh <= amp_sh << 1;
          cnt    <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          dsr   <= DRIVE_DEN;
          rem   <= acc[AW-1:QW];
          dvd   <= DVD_W'(acc[QW-1:0]) << (DVD_W - QW);
          cnt   <= CNT_W'(QW);
          state <= S_DDIV;
        end
        S_DDIV: begin
          rem <= rem_step;
          dvd <= {dvd[DVD_W-2:0], ge};
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= S_DEND;
          end
        end
        S_DEND: begin
          dac   <= direction_forward ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || sample.ready) begin
            out_dac    <= dac;
            out_level  <= level;
            out_phase  <= n_reg;
            out_active <= act_reg;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign sample.valid       = out_valid;
  assign sample.dac_level   = out_dac;
  assign sample.wave_level  = out_level;
  assign sample.phase_index = out_phase;
  assign sample.active      = out_active;

  `PWG_ASSERT_IMP(a_phase_in_range, state == S_PREP, phase_count < p_reg)
  `PWG_ASSERT_IMP(a_rem_below_div, (state == S_WDIV) || (state == S_DDIV), rem < dsr)
  `PWG_ASSERT_IMP(a_mag_in_range, state == S_DEND, mag <= QW'(DAC_MAX))
  `PWG_ASSERT_NXT(a_idle_after_out, (state == S_FINISH) && !out_valid, state == S_IDLE)

endmodule

[sim/tb_periodic_waveform_generator.sv]
// Self-checking testbench for periodic_waveform_generator: a directed pass and random
// passes under four idling profiles, checked against an in-bench sample predictor.
// Depends on pwg_pkg and the pwg_tick_if and pwg_sample_if interfaces of the RTL.
module tb_periodic_waveform_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import pwg_pkg::*;

  localparam int          DAC_FULL     = 1023;
  localparam int          DAC_W        = $clog2(DAC_FULL + 1) + 1;
  localparam int          QW_DEPTH     = 256;
  localparam int          DRAIN_CYCLES = 60;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam logic [2:0]  WAVE_SPARE_6 = 3'd6;
  localparam logic [2:0]  WAVE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [DAC_W-1:0] dac;
    logic [LEVEL_W-1:0]      level;
    logic [PHASE_W-1:0]      phase;
    logic                    active;
  } sample_t;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [1:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  pwg_tick_if                       tick_ch ();
  pwg_sample_if #(.DAC_W(DAC_W))    sample_ch ();

  periodic_waveform_generator #(.DAC_MAX(DAC_FULL)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .sample    (sample_ch)
  );

  logic [2:0]         wave_sel;
  logic [PHASE_W-1:0] period_sel;
  logic [AMP_W-1:0]   amp_sel;
  logic               fwd_sel;
  logic [PHASE_W-1:0] phase_ctr;

  int unsigned qwave [0:QW_DEPTH];
  sample_t     expected_samples [$];

  int err_count;
  int ticks_sent;
  int samples_seen;
  int restarts_sent;
  int writes_done;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Quarter-wave sine in Q0.16, from a Q30 Taylor series rounded half up.
  initial begin : quarter_wave_init
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint unsigned mag;
    longint unsigned rounded;
    longint          acc;
    for (int k = 0; k <= QW_DEPTH; k++) begin
      ang    = (64'd1686629713 * longint'(k)) / QW_DEPTH;
      ang_sq = (ang * ang) >> 30;
      term   = ang;
      acc    = longint'(ang);
      for (int i = 0; i < 8; i++) begin
        term = ((term * ang_sq) >> 30) / longint'((2 * i + 2) * (2 * i + 3));
        if (i % 2 == 0) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      mag     = (acc < 0) ? 64'd0 : longint'(acc);
      rounded = (mag * 64'd65535 + 64'd536870912) >> 30;
      if (rounded > 64'd65535) begin
        rounded = 64'd65535;
      end
      qwave[k] = int'(rounded);
    end
  end

  function automatic int unsigned ratio_q16(input int unsigned num, input int unsigned per);
    longint unsigned twice;
    twice = 64'd131070 * num + per;
    return int'(twice / (64'd2 * per));
  endfunction

  function automatic sample_t predict_sample(input logic rs);
    int unsigned     per;
    int unsigned     n;
    int unsigned     t;
    int unsigned     rem;
    int unsigned     span;
    int unsigned     level;
    int unsigned     amp;
    int unsigned     mag;
    int              cosv;
    longint unsigned num;
    longint unsigned den;
    sample_t         s;
    per = (period_sel == 0) ? 1 : period_sel;
    if (rs) begin
      phase_ctr = '0;
    end
    if (phase_ctr >= per) begin
      phase_ctr = '0;
    end
    n        = phase_ctr;
    level    = 0;
    mag      = 0;
    s.active = (wave_sel >= WAVE_SINE) && (wave_sel <= WAVE_SAW_FALL);
    if (s.active) begin
      case (wave_sel)
        WAVE_SINE: begin
          t   = int'((longint'(n) * 4 * QW_DEPTH) / per);
          rem = t % QW_DEPTH;
          case ((t / QW_DEPTH) % 4)
            0: cosv = int'(qwave[QW_DEPTH - rem]);
            1: cosv = -int'(qwave[rem]);
            2: cosv = -int'(qwave[QW_DEPTH - rem]);
            default: cosv = int'(qwave[rem]);
          endcase
          level = int'((int'(LEVEL_ONE) - cosv + 1) / 2);
        end
        WAVE_SQUARE: level = (n >= per / 2) ? 0 : int'(LEVEL_ONE);
        WAVE_TRIANGLE: begin
          span  = (per > 2 * n) ? per - 2 * n : 2 * n - per;
          level = ratio_q16(per - span, per);
        end
        WAVE_SAW_RISE: level = ratio_q16(n, per);
        default: level = ratio_q16(per - n, per);
      endcase
      amp       = (amp_sel > AMP_FULL) ? int'(AMP_FULL) : amp_sel;
      num       = longint'(level) * longint'(amp) * DAC_FULL;
      den       = 64'd655350000;
      mag       = int'((64'd2 * num + den) / (64'd2 * den));
      phase_ctr = (n + 1 >= per) ? '0 : PHASE_W'(n + 1);
    end
    s.dac = mag[DAC_W-1:0];
    if (!fwd_sel) begin
      s.dac = -s.dac;
    end
    s.level = level[LEVEL_W-1:0];
    s.phase = n[PHASE_W-1:0];
    return s;
  endfunction

  task automatic report_error(input string msg);
    err_count++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_sample();
    sample_t want;
    if (expected_samples.size() == 0) begin
      report_error($sformatf("unexpected sample, phase_index %0d", sample_ch.phase_index));
    end else begin
      want = expected_samples.pop_front();
      samples_seen++;
      if (sample_ch.dac_level !== want.dac) begin
        report_error($sformatf("sample %0d dac_level %0d, expected %0d", samples_seen,
                               sample_ch.dac_level, $signed(want.dac)));
      end
      if (sample_ch.wave_level !== want.level) begin
        report_error($sformatf("sample %0d wave_level %0d, expected %0d", samples_seen,
                               sample_ch.wave_level, want.level));
      end
      if (sample_ch.phase_index !== want.phase) begin
        report_error($sformatf("sample %0d phase_index %0d, expected %0d", samples_seen,
                               sample_ch.phase_index, want.phase));
      end
      if (sample_ch.active !== want.active) begin
        report_error($sformatf("sample %0d active %0b, expected %0b", samples_seen,
                               sample_ch.active, want.active));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      check_sample();
    end
  end

  initial begin
    sample_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      sample_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d samples outstanding", cycle_count,
             expected_samples.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_W'(val);
    case (idx)
      REG_WAVE_TYPE: wave_sel   = val[2:0];
      REG_PERIOD:    period_sel = val[PHASE_W-1:0];
      REG_AMPLITUDE: amp_sel    = val[AMP_W-1:0];
      REG_DIRECTION: fwd_sel    = val[0];
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic send_tick(input logic rs);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_ch.valid   = 1'b0;
      tick_ch.restart = 1'($urandom_range(1));
      @(negedge clk);
    end
    tick_ch.valid   = 1'b1;
    tick_ch.restart = rs;
    do @(posedge clk); while (!tick_ch.ready);
    expected_samples.push_back(predict_sample(rs));
    ticks_sent++;
    if (rs) begin
      restarts_sent++;
    end
  endtask

  task automatic wait_for_samples();
    @(negedge clk);
    tick_ch.valid = 1'b0;
    while (expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [2:0] w, input int unsigned per,
                               input int unsigned amp, input logic fwd);
    write_reg(REG_WAVE_TYPE, w);
    write_reg(REG_PERIOD, per);
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_DIRECTION, fwd);
  endtask

  task automatic test_after_reset();
    send_tick(1'b0);
    send_tick(1'b1);
    wait_for_samples();
  endtask

  task automatic test_wave_shapes();
    apply_setting(WAVE_OFF, 5, AMP_FULL, 1'b1);
    for (int w = WAVE_SINE; w <= WAVE_SAW_FALL; w++) begin
      write_reg(REG_WAVE_TYPE, w);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      wait_for_samples();
    end
  endtask

  task automatic test_spare_types();
    write_reg(REG_WAVE_TYPE, WAVE_SPARE_6);
    send_tick(1'b0);
    wait_for_samples();
    write_reg(REG_WAVE_TYPE, WAVE_SPARE_7);
    send_tick(1'b1);
    wait_for_samples();
  endtask

  task automatic test_register_extremes();
    apply_setting(WAVE_SINE, 0, 16383, 1'b0);
    send_tick(1'b0);
    wait_for_samples();
    apply_setting(WAVE_SAW_RISE, 4095, 0, 1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_for_samples();
    // The counter sits above the new period and must wrap to zero first.
    apply_setting(WAVE_SQUARE, 1, AMP_FULL, 1'b0);
    send_tick(1'b0);
    wait_for_samples();
    apply_setting(WAVE_TRIANGLE, 4095, 16383, 1'b1);
    send_tick(1'b1);
    wait_for_samples();
  endtask

  task automatic randomize_setting();
    if ($urandom_range(2) != 0) begin
      if ($urandom_range(19) < 17) begin
        write_reg(REG_WAVE_TYPE, $urandom_range(WAVE_SINE, WAVE_SAW_FALL));
      end else begin
        case ($urandom_range(2))
          0: write_reg(REG_WAVE_TYPE, WAVE_OFF);
          1: write_reg(REG_WAVE_TYPE, WAVE_SPARE_6);
          default: write_reg(REG_WAVE_TYPE, WAVE_SPARE_7);
        endcase
      end
    end
    if ($urandom_range(2) != 0) begin
      case ($urandom_range(9))
        0: write_reg(REG_PERIOD, $urandom_range(1));
        1: write_reg(REG_PERIOD, $urandom_range(2, 49));
        2: write_reg(REG_PERIOD, ($urandom_range(1) != 0) ? 4095 : 3000);
        3: write_reg(REG_PERIOD, $urandom_range(301, 4095));
        default: write_reg(REG_PERIOD, $urandom_range(50, 300));
      endcase
    end
    if ($urandom_range(2) != 0) begin
      case ($urandom_range(7))
        0: write_reg(REG_AMPLITUDE, 0);
        1: write_reg(REG_AMPLITUDE, AMP_FULL);
        2: write_reg(REG_AMPLITUDE, 16383);
        3: write_reg(REG_AMPLITUDE, $urandom_range(10001, 16383));
        default: write_reg(REG_AMPLITUDE, $urandom_range(0, 10000));
      endcase
    end
    if ($urandom_range(2) != 0) begin
      write_reg(REG_DIRECTION, $urandom_range(1));
    end
  endtask

  task automatic test_random_ticks(input int s_idle, input int r_stall, input int n_items);
    int left;
    int chunk;
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    left           = n_items;
    while (left > 0) begin
      randomize_setting();
      chunk = $urandom_range(10, 60);
      if (chunk > left) begin
        chunk = left;
      end
      repeat (chunk) send_tick($urandom_range(11) == 0);
      left -= chunk;
      wait_for_samples();
    end
  endtask

  initial begin
    err_count       = 0;
    ticks_sent      = 0;
    samples_seen    = 0;
    restarts_sent   = 0;
    writes_done     = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = REG_WAVE_TYPE;
    cfg_data        = '0;
    tick_ch.valid   = 1'b0;
    tick_ch.restart = 1'b0;
    wave_sel        = WAVE_OFF;
    period_sel      = PERIOD_RST;
    amp_sel         = AMP_FULL;
    fwd_sel         = 1'b1;
    phase_ctr       = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_after_reset();
    test_wave_shapes();
    test_spare_types();
    test_register_extremes();
    test_random_ticks(0, 0, 282);
    test_random_ticks(80, 0, 282);
    test_random_ticks(0, 80, 282);
    test_random_ticks(22, 22, 282);

    if (expected_samples.size() != 0) begin
      report_error($sformatf("%0d samples never arrived", expected_samples.size()));
    end
    $display("Run covered %0d ticks (%0d with restart) and %0d checked samples", ticks_sent,
             restarts_sent, samples_seen);
    $display("over %0d register writes and four idling profiles.", writes_done);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
